@@ hdl/qfs_pkg.sv @@
// Shared types and constants for the quoted field splitter.
// No dependencies; imported by the front end, command queue, back end and top level.
package qfs_pkg;

    localparam int LEN_W = 6;

    typedef logic [LEN_W-1:0] t_len;
    typedef logic [7:0]       t_char;

    localparam t_char QUOTE_DQ = 8'd34;
    localparam t_char QUOTE_SQ = 8'd39;
    localparam t_char NO_QUOTE = 8'd32;

    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_EMPTY,
        TAIL_CHAR
    } t_tail;

    // one field to emit, plus an optional one-item field after it
    typedef struct packed {
        logic  bank;
        logic  strip;
        logic  empty;
        t_len  hi;
        logic  ovf;
        t_char last_char;
        logic  str_last;
        t_tail tail;
        t_char tail_char;
    } t_cmd;

    typedef struct packed {
        logic  en;
        logic  bank;
        t_len  addr;
        t_char data;
    } t_wr;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_rel;

endpackage

@@ hdl/qfs_front.sv @@
// Front end: configuration registers, character classification and field state.
// Writes characters into the buffer banks and pushes emit commands. Uses qfs_pkg.
module qfs_front #(
    parameter int MAX_FIELD = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  logic [2:0]     i_cfg_index,
    input  logic [7:0]     i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic [7:0]     i_in_char,
    input  logic           i_in_string_last,
    output logic           o_push,
    output qfs_pkg::t_cmd  o_cmd,
    input  logic           i_full,
    output qfs_pkg::t_wr   o_wr,
    input  qfs_pkg::t_rel  i_rel
);
    import qfs_pkg::*;

    localparam logic [2:0] CFG_DMODE  = 3'd0;
    localparam logic [2:0] CFG_QUOTES = 3'd1;
    localparam logic [2:0] CFG_DCOUNT = 3'd2;
    localparam logic [2:0] CFG_DCHAR0 = 3'd3;
    localparam logic [2:0] CFG_DCHAR1 = 3'd4;
    localparam logic [2:0] CFG_DCHAR2 = 3'd5;
    localparam logic [2:0] CFG_DCHAR3 = 3'd6;
    localparam t_len MAX_LEN = t_len'(MAX_FIELD);

    logic        r_dmode, r_qe;
    logic [2:0]  r_dcnt;
    t_char       r_dc [4];

    t_len        r_len;
    t_char       r_first, r_last, r_oq;
    logic        r_inf, r_ovf, r_pend, r_bank;
    logic [1:0]  r_busy;

    t_len        n_len;
    t_char       n_first, n_last, n_oq;
    logic        n_inf, n_ovf, n_pend, n_bank;
    logic [1:0]  n_busy;

    logic        accept, is_d, is_q;
    logic        fc_del, fc_app;
    t_char       fc_oq;
    logic        clr_pre, do_app, emit_pre, emit_post, wbank;
    logic        p_inf, p_pend;
    t_char       p_oq;
    t_tail       tail;
    t_len        a_len;
    t_char       a_first, a_last;
    logic        a_inf, a_ovf, a_pend;
    logic        final_clear;
    t_wr         wr;

    function automatic logic quote_chr(input t_char c);
        quote_chr = (c == QUOTE_DQ) || (c == QUOTE_SQ);
    endfunction

    function automatic t_cmd mk_cmd(input t_len len, input t_char fc, input t_char lc,
                                    input logic ovf, input logic bank, input logic qe,
                                    input logic sl, input t_tail tl, input t_char tc);
        t_cmd cmd;
        logic strip;
        strip         = qe && (len >= t_len'(2)) && quote_chr(fc) && (lc == fc);
        cmd.bank      = bank;
        cmd.strip     = strip;
        cmd.empty     = (len == '0) || (strip && len == t_len'(2));
        cmd.hi        = strip ? len - t_len'(1) : len;
        cmd.ovf       = ovf;
        cmd.last_char = lc;
        cmd.str_last  = sl;
        cmd.tail      = tl;
        cmd.tail_char = tc;
        mk_cmd        = cmd;
    endfunction

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = i_full || r_busy[~r_bank];
    assign is_q       = quote_chr(i_in_char);

    always_comb begin
        is_d = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if ((3'(k) < r_dcnt) && (r_dc[k] == i_in_char)) is_d = 1'b1;
        end
    end

    // classify a character inside a field: delimiter, or appended with quote tracking
    always_comb begin
        fc_del = 1'b0;
        fc_app = 1'b0;
        fc_oq  = r_oq;
        if (r_qe && r_oq != NO_QUOTE) begin
            if (i_in_char == r_oq) fc_oq = NO_QUOTE;
            fc_app = 1'b1;
        end else if (r_len != '0 && r_qe && is_q) begin
            fc_oq  = i_in_char;
            fc_app = 1'b1;
        end else if (is_d) begin
            fc_del = 1'b1;
        end else begin
            if (r_qe && is_q) fc_oq = i_in_char;
            fc_app = 1'b1;
        end
    end

    always_comb begin
        clr_pre   = 1'b0;
        do_app    = 1'b0;
        emit_pre  = 1'b0;
        emit_post = 1'b0;
        wbank     = r_bank;
        p_oq      = r_oq;
        p_inf     = r_inf;
        p_pend    = r_pend;
        tail      = TAIL_NONE;
        if (r_dmode) begin
            p_pend = 1'b0;
            if (r_pend) p_inf = 1'b1;
            if (fc_del) begin
                emit_pre = 1'b1;
                tail     = i_in_string_last ? TAIL_EMPTY : TAIL_NONE;
            end else begin
                p_oq      = fc_oq;
                do_app    = fc_app;
                emit_post = i_in_string_last;
            end
        end else begin
            if (r_inf) begin
                if (fc_del) begin
                    p_inf  = 1'b0;
                    p_pend = 1'b1;
                    p_oq   = NO_QUOTE;
                end else begin
                    p_oq   = fc_oq;
                    do_app = fc_app;
                end
            end else if (!is_d) begin
                clr_pre = 1'b1;
                do_app  = 1'b1;
                p_oq    = (r_qe && is_q) ? i_in_char : NO_QUOTE;
                if (r_pend) begin
                    emit_pre = 1'b1;
                    wbank    = ~r_bank;
                    tail     = i_in_string_last ? TAIL_CHAR : TAIL_NONE;
                end
            end
            emit_post = i_in_string_last && !emit_pre && (p_inf || p_pend || do_app);
        end
    end

    always_comb begin
        a_len   = clr_pre ? '0 : r_len;
        a_first = clr_pre ? '0 : r_first;
        a_last  = clr_pre ? '0 : r_last;
        a_ovf   = clr_pre ? 1'b0 : r_ovf;
        a_pend  = clr_pre ? 1'b0 : p_pend;
        a_inf   = p_inf;
        wr      = '0;
        wr.bank = wbank;
        wr.data = i_in_char;
        if (do_app) begin
            if (a_len == '0) a_first = i_in_char;
            if (a_len < MAX_LEN) begin
                wr.en   = accept;
                wr.addr = a_len;
                a_len   = a_len + t_len'(1);
            end else begin
                a_ovf = 1'b1;
            end
            a_last = i_in_char;
            a_inf  = 1'b1;
        end
    end

    assign o_push = accept && (emit_pre || emit_post);
    assign o_cmd  = emit_pre ?
        mk_cmd(r_len, r_first, r_last, r_ovf, r_bank, r_qe, 1'b0, tail, i_in_char) :
        mk_cmd(a_len, a_first, a_last, a_ovf, r_bank, r_qe, 1'b1, TAIL_NONE, i_in_char);
    assign o_wr   = wr;

    assign final_clear = r_dmode ? (emit_pre || emit_post) : i_in_string_last;

    always_comb begin
        n_len   = r_len;
        n_first = r_first;
        n_last  = r_last;
        n_oq    = r_oq;
        n_inf   = r_inf;
        n_ovf   = r_ovf;
        n_pend  = r_pend;
        n_bank  = r_bank;
        if (accept) begin
            if (final_clear) begin
                n_len   = '0;
                n_first = '0;
                n_last  = '0;
                n_oq    = NO_QUOTE;
                n_inf   = 1'b0;
                n_ovf   = 1'b0;
                n_pend  = 1'b0;
            end else begin
                n_len   = a_len;
                n_first = a_first;
                n_last  = a_last;
                n_oq    = p_oq;
                n_inf   = a_inf;
                n_ovf   = a_ovf;
                n_pend  = a_pend;
            end
            if (o_push) n_bank = ~r_bank;
        end
        n_busy = r_busy;
        if (i_rel.valid) n_busy[i_rel.bank] = 1'b0;
        if (o_push) n_busy[r_bank] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dmode <= 1'b1;
            r_qe    <= 1'b0;
            r_dcnt  <= 3'd1;
            r_dc[0] <= 8'd44;
            r_dc[1] <= 8'd0;
            r_dc[2] <= 8'd0;
            r_dc[3] <= 8'd0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_DMODE:  r_dmode <= i_cfg_data[0];
                CFG_QUOTES: r_qe    <= i_cfg_data[0];
                CFG_DCOUNT: r_dcnt  <= i_cfg_data[2:0];
                CFG_DCHAR0: r_dc[0] <= i_cfg_data;
                CFG_DCHAR1: r_dc[1] <= i_cfg_data;
                CFG_DCHAR2: r_dc[2] <= i_cfg_data;
                CFG_DCHAR3: r_dc[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_first <= '0;
            r_last  <= '0;
            r_oq    <= NO_QUOTE;
            r_inf   <= 1'b0;
            r_ovf   <= 1'b0;
            r_pend  <= 1'b0;
            r_bank  <= 1'b0;
            r_busy  <= '0;
        end else begin
            r_len   <= n_len;
            r_first <= n_first;
            r_last  <= n_last;
            r_oq    <= n_oq;
            r_inf   <= n_inf;
            r_ovf   <= n_ovf;
            r_pend  <= n_pend;
            r_bank  <= n_bank;
            r_busy  <= n_busy;
        end
    end

endmodule

@@ hdl/qfs_cmd_fifo.sv @@
// Two-entry queue of emit commands between front end and back end.
// Uses qfs_pkg for the command type.
module qfs_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  qfs_pkg::t_cmd  i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output qfs_pkg::t_cmd  o_cmd,
    output logic           o_empty
);
    import qfs_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 2'd1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 2'd1;
        end
        if (i_push) r_q[r_wp] <= i_cmd;
    end

endmodule

@@ hdl/qfs_back.sv @@
// Back end: two-bank field buffer and the emitter that reads a field out one item per cycle
// unless stalled. Takes commands from qfs_cmd_fifo, frees banks to qfs_front. Uses qfs_pkg.
module qfs_back #(
    parameter int MAX_FIELD = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  qfs_pkg::t_wr   i_wr,
    input  logic           i_q_empty,
    input  qfs_pkg::t_cmd  i_q_cmd,
    output logic           o_pop,
    output qfs_pkg::t_rel  o_rel,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [7:0]     o_out_char,
    output logic           o_has_char,
    output logic           o_field_last,
    output logic           o_out_string_last,
    output logic           o_field_truncated
);
    import qfs_pkg::*;

    localparam int AW = $clog2(MAX_FIELD);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIELD,
        S_TAIL
    } t_state;

    typedef struct packed {
        logic  from_mem;
        t_char alt_char;
        logic  has_char;
        logic  field_last;
        logic  str_last;
        logic  trunc;
    } t_item;

    typedef struct packed {
        t_char ch;
        logic  has_char;
        logic  field_last;
        logic  str_last;
        logic  trunc;
    } t_out;

    t_char  r_mem [2][MAX_FIELD];
    t_char  r_rd_data;

    t_state r_state, n_state;
    t_cmd   r_cmd, n_cmd;
    t_len   r_idx, n_idx;
    logic   r_rd_v, n_rd_v;
    t_item  r_rd_item, n_rd_item;
    logic   r_o_v, n_o_v;
    t_out   r_out, n_out;

    logic   rd_move, issue_ok, iss, rd_en, last_i;
    t_item  item;

    assign rd_move  = r_rd_v && (!r_o_v || !i_out_stall);
    assign issue_ok = !r_rd_v || rd_move;
    assign last_i   = (r_idx == r_cmd.hi - t_len'(1));

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_idx   = r_idx;
        o_pop   = 1'b0;
        o_rel   = '0;
        iss     = 1'b0;
        rd_en   = 1'b0;
        item    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_idx   = t_len'(i_q_cmd.strip);
                    n_state = S_FIELD;
                end
            end
            S_FIELD: begin
                if (issue_ok) begin
                    iss = 1'b1;
                    if (r_cmd.empty) begin
                        item.field_last = 1'b1;
                        item.str_last   = r_cmd.str_last;
                        item.trunc      = r_cmd.ovf;
                    end else begin
                        rd_en           = 1'b1;
                        item.from_mem   = !(r_cmd.ovf && !r_cmd.strip && last_i);
                        item.alt_char   = r_cmd.last_char;
                        item.has_char   = 1'b1;
                        item.field_last = last_i;
                        item.str_last   = r_cmd.str_last && last_i;
                        item.trunc      = r_cmd.ovf;
                        n_idx           = r_idx + t_len'(1);
                    end
                    if (r_cmd.empty || last_i) begin
                        o_rel.valid = 1'b1;
                        o_rel.bank  = r_cmd.bank;
                        n_state     = (r_cmd.tail == TAIL_NONE) ? S_IDLE : S_TAIL;
                    end
                end
            end
            S_TAIL: begin
                if (issue_ok) begin
                    iss             = 1'b1;
                    item.has_char   = (r_cmd.tail == TAIL_CHAR);
                    item.alt_char   = (r_cmd.tail == TAIL_CHAR) ? r_cmd.tail_char : '0;
                    item.field_last = 1'b1;
                    item.str_last   = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_rd_v    = r_rd_v;
        n_rd_item = r_rd_item;
        if (iss) begin
            n_rd_v    = 1'b1;
            n_rd_item = item;
        end else if (rd_move) begin
            n_rd_v = 1'b0;
        end
        n_o_v = r_o_v;
        n_out = r_out;
        if (rd_move) begin
            n_o_v          = 1'b1;
            n_out.ch       = r_rd_item.from_mem ? r_rd_data : r_rd_item.alt_char;
            n_out.has_char = r_rd_item.has_char;
            n_out.field_last = r_rd_item.field_last;
            n_out.str_last = r_rd_item.str_last;
            n_out.trunc    = r_rd_item.trunc;
        end else if (!i_out_stall) begin
            n_o_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) r_mem[i_wr.bank][i_wr.addr[AW-1:0]] <= i_wr.data;
        if (rd_en)   r_rd_data <= r_mem[r_cmd.bank][r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rd_v  <= 1'b0;
            r_o_v   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= n_rd_v;
            r_o_v   <= n_o_v;
        end
        r_cmd     <= n_cmd;
        r_idx     <= n_idx;
        r_rd_item <= n_rd_item;
        r_out     <= n_out;
    end

    assign o_out_valid       = r_o_v;
    assign o_out_char        = r_out.ch;
    assign o_has_char        = r_out.has_char;
    assign o_field_last      = r_out.field_last;
    assign o_out_string_last = r_out.str_last;
    assign o_field_truncated = r_out.trunc;

endmodule

@@ hdl/quoted_field_splitter_top.sv @@
// Quoted field splitter, top level. While not stalled, one character request per cycle enters
// the field buffer until a field ends; the field is then read back one item per cycle while
// the output is not stalled, and the emitter passes through its idle state between fields. After a
// field end requests stall until its last item has been read from the buffer.
// Synchronous active-low reset clears control state and loads register defaults;
// buffer contents are not cleared. Depends on qfs_pkg, qfs_front, qfs_cmd_fifo, qfs_back.
module quoted_field_splitter_top #(
    parameter int MAX_FIELD = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_char,
    input  logic       i_in_string_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_char,
    output logic       o_has_char,
    output logic       o_field_last,
    output logic       o_out_string_last,
    output logic       o_field_truncated
);
    import qfs_pkg::*;

    logic push, full, pop, empty;
    t_cmd push_cmd, pop_cmd;
    t_wr  wr;
    t_rel rel;

    qfs_front #(.MAX_FIELD(MAX_FIELD)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_char        (i_in_char),
        .i_in_string_last (i_in_string_last),
        .o_push           (push),
        .o_cmd            (push_cmd),
        .i_full           (full),
        .o_wr             (wr),
        .i_rel            (rel)
    );

    qfs_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (pop_cmd),
        .o_empty (empty)
    );

    qfs_back #(.MAX_FIELD(MAX_FIELD)) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_wr              (wr),
        .i_q_empty         (empty),
        .i_q_cmd           (pop_cmd),
        .o_pop             (pop),
        .o_rel             (rel),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_out_char        (o_out_char),
        .o_has_char        (o_has_char),
        .o_field_last      (o_field_last),
        .o_out_string_last (o_out_string_last),
        .o_field_truncated (o_field_truncated)
    );

endmodule
